### sv/gnsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnsp_pkg
// Shared constants, the parser phase encoding and the navigation result
// record for the navigation solution frame parser.
// ----------------------------------------------------------------------------
package gnsp_pkg;

  // Frame header bytes.
  localparam logic [7:0] FRAME_SYNC1  = 8'hB5;
  localparam logic [7:0] FRAME_SYNC2  = 8'h62;
  localparam logic [7:0] FRAME_CLASS  = 8'h01;
  localparam logic [7:0] FRAME_ID     = 8'h06;
  localparam logic [7:0] FRAME_LEN_LO = 8'h34;
  localparam logic [7:0] FRAME_LEN_HI = 8'h00;

  // Payload geometry.
  localparam int unsigned PAYLOAD_LEN = 52;
  localparam int unsigned CNT_W       = 6;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAYLOAD_LEN - 1);

  // Payload byte offsets of the fields we keep.
  localparam logic [CNT_W-1:0] OFS_FIX   = CNT_W'(10);
  localparam logic [CNT_W-1:0] OFS_FLAGS = CNT_W'(11);
  // The 32-bit words are aligned to four bytes, so they are picked out by
  // the upper count bits.
  localparam logic [CNT_W-3:0] WRD_PX = (CNT_W-2)'(12 / 4);
  localparam logic [CNT_W-3:0] WRD_PY = (CNT_W-2)'(16 / 4);
  localparam logic [CNT_W-3:0] WRD_PZ = (CNT_W-2)'(20 / 4);
  localparam logic [CNT_W-3:0] WRD_VX = (CNT_W-2)'(28 / 4);
  localparam logic [CNT_W-3:0] WRD_VY = (CNT_W-2)'(32 / 4);
  localparam logic [CNT_W-3:0] WRD_VZ = (CNT_W-2)'(36 / 4);

  // Parser phases, one-hot.
  typedef enum logic [6:0] {
    PH_SYNC1   = 7'b0000001,
    PH_SYNC2   = 7'b0000010,
    PH_CLASS   = 7'b0000100,
    PH_ID      = 7'b0001000,
    PH_LEN_LO  = 7'b0010000,
    PH_LEN_HI  = 7'b0100000,
    PH_PAYLOAD = 7'b1000000
  } phase_t;

  // One decoded navigation solution.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [7:0]         fix_type;
    logic               fix_ok;
  } nav_result_t;

endpackage

### sv/gnsp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnsp_parser
// Header sequencer and payload field capture. Consumes one byte per enabled
// cycle, flags the last payload byte and holds the assembled fields.
// ----------------------------------------------------------------------------
module gnsp_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_en,
  input  logic [7:0]            rx_data,
  output logic                  last,
  output gnsp_pkg::nav_result_t result
);

  gnsp_pkg::phase_t                 phase;
  gnsp_pkg::phase_t                 phase_next;
  logic [gnsp_pkg::CNT_W-1:0]       count;
  logic [gnsp_pkg::CNT_W-1:0]       count_next;
  gnsp_pkg::nav_result_t            fields;
  logic [gnsp_pkg::CNT_W-3:0]       word_sel;
  logic [4:0]                       lane;

  assign word_sel = count[gnsp_pkg::CNT_W-1:2];
  assign lane     = {count[1:0], 3'b000};

  // The frame ends on the final payload byte.
  assign last   = (phase == gnsp_pkg::PH_PAYLOAD) && (count == gnsp_pkg::CNT_LAST);
  assign result = fields;

  // Header sequencer. A mismatch drops back to hunting without re-checking
  // the byte as a new sync; unused phase codes behave as hunting.
  always_comb begin
    phase_next = phase;
    count_next = '0;
    case (phase)
      gnsp_pkg::PH_SYNC2: begin
        phase_next = (rx_data == gnsp_pkg::FRAME_SYNC2) ? gnsp_pkg::PH_CLASS
                                                        : gnsp_pkg::PH_SYNC1;
      end
      gnsp_pkg::PH_CLASS: begin
        phase_next = (rx_data == gnsp_pkg::FRAME_CLASS) ? gnsp_pkg::PH_ID
                                                        : gnsp_pkg::PH_SYNC1;
      end
      gnsp_pkg::PH_ID: begin
        phase_next = (rx_data == gnsp_pkg::FRAME_ID) ? gnsp_pkg::PH_LEN_LO
                                                     : gnsp_pkg::PH_SYNC1;
      end
      gnsp_pkg::PH_LEN_LO: begin
        phase_next = (rx_data == gnsp_pkg::FRAME_LEN_LO) ? gnsp_pkg::PH_LEN_HI
                                                         : gnsp_pkg::PH_SYNC1;
      end
      gnsp_pkg::PH_LEN_HI: begin
        phase_next = (rx_data == gnsp_pkg::FRAME_LEN_HI) ? gnsp_pkg::PH_PAYLOAD
                                                         : gnsp_pkg::PH_SYNC1;
      end
      gnsp_pkg::PH_PAYLOAD: begin
        if (last) begin
          phase_next = gnsp_pkg::PH_SYNC1;
        end else begin
          count_next = count + 1'b1;
        end
      end
      default: begin
        phase_next = (rx_data == gnsp_pkg::FRAME_SYNC1) ? gnsp_pkg::PH_SYNC2
                                                        : gnsp_pkg::PH_SYNC1;
      end
    endcase
  end

  // Phase and payload count.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= gnsp_pkg::PH_SYNC1;
      count <= '0;
    end else if (byte_en) begin
      phase <= phase_next;
      count <= count_next;
    end
  end

  // Field capture: each payload byte lands directly in the field it belongs to.
  always_ff @(posedge clk) begin
    if (byte_en && (phase == gnsp_pkg::PH_PAYLOAD)) begin
      if (count == gnsp_pkg::OFS_FIX) begin
        fields.fix_type <= rx_data;
      end
      if (count == gnsp_pkg::OFS_FLAGS) begin
        fields.fix_ok <= rx_data[0];
      end
      if (word_sel == gnsp_pkg::WRD_PX) begin
        fields.pos_x[lane +: 8] <= rx_data;
      end
      if (word_sel == gnsp_pkg::WRD_PY) begin
        fields.pos_y[lane +: 8] <= rx_data;
      end
      if (word_sel == gnsp_pkg::WRD_PZ) begin
        fields.pos_z[lane +: 8] <= rx_data;
      end
      if (word_sel == gnsp_pkg::WRD_VX) begin
        fields.vel_x[lane +: 8] <= rx_data;
      end
      if (word_sel == gnsp_pkg::WRD_VY) begin
        fields.vel_y[lane +: 8] <= rx_data;
      end
      if (word_sel == gnsp_pkg::WRD_VZ) begin
        fields.vel_z[lane +: 8] <= rx_data;
      end
    end
  end

endmodule

### sv/gnss_nav_solution_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnss_nav_solution_frame_parser
// A result is valid in the cycle after its last payload beat is taken.
// One byte beat per cycle, set by the input register and the header sequencer,
// but a frame's last beat waits while the output is full; the output register
// frees the input side. Reset (synchronous, active high) empties both
// registers and sends the sequencer back to hunting for the first sync byte.
// ----------------------------------------------------------------------------
module gnss_nav_solution_frame_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] vel_z,
  output logic [7:0]         fix_type,
  output logic               fix_ok
);

  logic                  byte_valid;
  logic [7:0]            byte_q;
  logic                  byte_fire;
  logic                  frame_last;
  logic                  out_free;
  gnsp_pkg::nav_result_t nav;
  gnsp_pkg::nav_result_t out_q;

  // The held byte moves on unless it closes a frame and the output is full.
  assign out_free  = !out_valid || out_ready;
  assign byte_fire = byte_valid && (!frame_last || out_free);
  assign rx_ready  = !byte_valid || byte_fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (rx_ready) begin
      byte_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      byte_q <= rx_byte;
    end
  end

  gnsp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .byte_en (byte_fire),
    .rx_data (byte_q),
    .last    (frame_last),
    .result  (nav)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (byte_fire && frame_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_fire && frame_last) begin
      out_q <= nav;
    end
  end

  assign pos_x    = out_q.pos_x;
  assign pos_y    = out_q.pos_y;
  assign pos_z    = out_q.pos_z;
  assign vel_x    = out_q.vel_x;
  assign vel_y    = out_q.vel_y;
  assign vel_z    = out_q.vel_z;
  assign fix_type = out_q.fix_type;
  assign fix_ok   = out_q.fix_ok;

endmodule
